// File: hdl/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg: shared types and constants of the ray/triangle intersect unit
// Register indexes, register widths and reset values.
// ----------------------------------------------------------------------------
package rti_pkg;

	localparam int FIELD_W = 60;
	localparam int EPS_W   = 40;
	localparam int MIND_W  = 24;

	localparam logic [EPS_W-1:0]  EPS_RESET  = 40'd687194;
	localparam logic [MIND_W-1:0] MIND_RESET = 24'd168;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_DET_EPSILON  = 2'd0,
		CFG_MIN_DISTANCE = 2'd1
	} cfg_idx_t;

endpackage

// File: hdl/rti_front.sv
// ----------------------------------------------------------------------------
// rti_front: unpack, edge vectors and cross products
// Stage 1 forms direction, both edges and the origin offset; stage 2 forms
// h = dir x e2 and q = s x e1.
// ----------------------------------------------------------------------------
module rti_front #(
	parameter int C = 20
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [rti_pkg::FIELD_W-1:0] ray_origin,
	input  logic [rti_pkg::FIELD_W-1:0] ray_direction,
	input  logic [rti_pkg::FIELD_W-1:0] vertex_a,
	input  logic [rti_pkg::FIELD_W-1:0] vertex_b,
	input  logic [rti_pkg::FIELD_W-1:0] vertex_c,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [C:0]     d_o  [3],
	output logic signed [C:0]     e1_o [3],
	output logic signed [C:0]     e2_o [3],
	output logic signed [C:0]     s_o  [3],
	output logic signed [2*C+2:0] h_o  [3],
	output logic signed [2*C+2:0] q_o  [3]
);
	localparam int DW = C + 1;
	localparam int XW = 2 * C + 3;
	localparam int FW = 3 * C;

	logic [FW-1:0] org_x, dir_x, va_x, vb_x, vc_x;
	logic signed [DW-1:0] d_c [3], e1_c [3], e2_c [3], s_c [3];
	logic signed [DW-1:0] d_s1 [3], e1_s1 [3], e2_s1 [3], s_s1 [3];
	logic signed [DW-1:0] d_s2 [3], e1_s2 [3], e2_s2 [3], s_s2 [3];
	logic signed [XW-1:0] h_c [3], q_c [3], h_s2 [3], q_s2 [3];
	logic vld_s1, vld_s2, rdy1, rdy2;

	// Bits beyond the field read as zero
	assign org_x = FW'(ray_origin);
	assign dir_x = FW'(ray_direction);
	assign va_x  = FW'(vertex_a);
	assign vb_x  = FW'(vertex_b);
	assign vc_x  = FW'(vertex_c);

	assign rdy2     = !vld_s2 || out_ready;
	assign rdy1     = !vld_s1 || rdy2;
	assign in_ready = rdy1;

	// Subtract vertex A
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			d_c[k]  = DW'($signed(dir_x[k*C +: C]));
			e1_c[k] = DW'($signed(vb_x[k*C +: C])) - DW'($signed(va_x[k*C +: C]));
			e2_c[k] = DW'($signed(vc_x[k*C +: C])) - DW'($signed(va_x[k*C +: C]));
			s_c[k]  = DW'($signed(org_x[k*C +: C])) - DW'($signed(va_x[k*C +: C]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= in_valid;
			if (rdy2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy1) begin
			d_s1 <= d_c; e1_s1 <= e1_c; e2_s1 <= e2_c; s_s1 <= s_c;
		end
	end

	// Cross products
	always_comb begin
		h_c[0] = XW'(d_s1[1]) * XW'(e2_s1[2]) - XW'(d_s1[2]) * XW'(e2_s1[1]);
		h_c[1] = XW'(d_s1[2]) * XW'(e2_s1[0]) - XW'(d_s1[0]) * XW'(e2_s1[2]);
		h_c[2] = XW'(d_s1[0]) * XW'(e2_s1[1]) - XW'(d_s1[1]) * XW'(e2_s1[0]);
		q_c[0] = XW'(s_s1[1]) * XW'(e1_s1[2]) - XW'(s_s1[2]) * XW'(e1_s1[1]);
		q_c[1] = XW'(s_s1[2]) * XW'(e1_s1[0]) - XW'(s_s1[0]) * XW'(e1_s1[2]);
		q_c[2] = XW'(s_s1[0]) * XW'(e1_s1[1]) - XW'(s_s1[1]) * XW'(e1_s1[0]);
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && rdy2) begin
			d_s2 <= d_s1; e1_s2 <= e1_s1; e2_s2 <= e2_s1; s_s2 <= s_s1;
			h_s2 <= h_c;  q_s2 <= q_c;
		end
	end

	assign out_valid = vld_s2;
	assign d_o  = d_s2;
	assign e1_o = e1_s2;
	assign e2_o = e2_s2;
	assign s_o  = s_s2;
	assign h_o  = h_s2;
	assign q_o  = q_s2;

endmodule

// File: hdl/rti_dot.sv
// ----------------------------------------------------------------------------
// rti_dot: determinant and numerators
// Stage 3 forms a, U, V, T as dot products; stage 4 negates all four when
// the determinant is negative, so that the determinant is not negative.
// ----------------------------------------------------------------------------
module rti_dot #(
	parameter int C = 20
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [C:0]     d_i  [3],
	input  logic signed [C:0]     e1_i [3],
	input  logic signed [C:0]     e2_i [3],
	input  logic signed [C:0]     s_i  [3],
	input  logic signed [2*C+2:0] h_i  [3],
	input  logic signed [2*C+2:0] q_i  [3],
	output logic out_valid,
	input  logic out_ready,
	output logic signed [3*C+5:0] a_o,
	output logic signed [3*C+5:0] u_o,
	output logic signed [3*C+5:0] v_o,
	output logic signed [3*C+5:0] t_o
);
	localparam int AW = 3 * C + 6;

	logic signed [AW-1:0] a_c, u_c, v_c, t_c;
	logic signed [AW-1:0] a_s3, u_s3, v_s3, t_s3;
	logic signed [AW-1:0] a_s4, u_s4, v_s4, t_s4;
	logic vld_s3, vld_s4, rdy3, rdy4, neg;

	assign rdy4     = !vld_s4 || out_ready;
	assign rdy3     = !vld_s3 || rdy4;
	assign in_ready = rdy3;

	// Dot products
	always_comb begin
		a_c = '0; u_c = '0; v_c = '0; t_c = '0;
		for (int k = 0; k < 3; k++) begin
			a_c = a_c + AW'(e1_i[k]) * AW'(h_i[k]);
			u_c = u_c + AW'(s_i[k])  * AW'(h_i[k]);
			v_c = v_c + AW'(d_i[k])  * AW'(q_i[k]);
			t_c = t_c + AW'(e2_i[k]) * AW'(q_i[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy3) vld_s3 <= in_valid;
			if (rdy4) vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy3) begin
			a_s3 <= a_c; u_s3 <= u_c; v_s3 <= v_c; t_s3 <= t_c;
		end
	end

	// Make the determinant non-negative
	assign neg = a_s3[AW-1];

	always_ff @(posedge clk) begin
		if (vld_s3 && rdy4) begin
			a_s4 <= neg ? -a_s3 : a_s3;
			u_s4 <= neg ? -u_s3 : u_s3;
			v_s4 <= neg ? -v_s3 : v_s3;
			t_s4 <= neg ? -t_s3 : t_s3;
		end
	end

	assign out_valid = vld_s4;
	assign a_o = a_s4;
	assign u_o = u_s4;
	assign v_o = v_s4;
	assign t_o = t_s4;

endmodule

// File: hdl/rti_test.sv
// ----------------------------------------------------------------------------
// rti_test: hit decision
// Stage 5 runs the determinant and barycentric compares and splits a * m
// into two partial products; stage 6 finishes the distance compare.
// ----------------------------------------------------------------------------
module rti_test #(
	parameter int C = 20
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [3*C+5:0] a_i,
	input  logic signed [3*C+5:0] u_i,
	input  logic signed [3*C+5:0] v_i,
	input  logic signed [3*C+5:0] t_i,
	input  logic [rti_pkg::EPS_W-1:0]  det_epsilon,
	input  logic [rti_pkg::MIND_W-1:0] min_distance,
	output logic out_valid,
	input  logic out_ready,
	output logic hit
);
	localparam int AW  = 3 * C + 6;
	localparam int LOW = (AW + 1) / 2;
	localparam int HIW = AW - LOW;
	localparam int MW  = rti_pkg::MIND_W;
	localparam int RW  = AW + MW + 1;

	logic signed [AW-1:0] eps_x;
	logic signed [AW:0]   uv_sum;
	logic fail_c, fail_s5, vld_s5, vld_s6, rdy5, rdy6, hit_s6;
	logic [LOW+MW-1:0] pp_lo_s5;
	logic [HIW+MW-1:0] pp_hi_s5;
	logic signed [AW-1:0] t_s5;
	logic signed [RW-1:0] lhs, rhs;

	assign rdy6     = !vld_s6 || out_ready;
	assign rdy5     = !vld_s5 || rdy6;
	assign in_ready = rdy5;

	// Determinant and barycentric bounds
	assign eps_x  = $signed(AW'(det_epsilon));
	assign uv_sum = (AW+1)'(u_i) + (AW+1)'(v_i);
	assign fail_c = (a_i == '0) || (a_i < eps_x)
		|| u_i[AW-1] || (a_i < u_i)
		|| v_i[AW-1] || ((AW+1)'(a_i) < uv_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (rdy5) vld_s5 <= in_valid;
			if (rdy6) vld_s6 <= vld_s5;
		end
	end

	// Split a * min_distance into two partial products
	always_ff @(posedge clk) begin
		if (in_valid && rdy5) begin
			fail_s5  <= fail_c;
			t_s5     <= t_i;
			pp_lo_s5 <= (LOW+MW)'(a_i[LOW-1:0]) * (LOW+MW)'(min_distance);
			pp_hi_s5 <= (HIW+MW)'(a_i[AW-1:LOW]) * (HIW+MW)'(min_distance);
		end
	end

	// Distance: T * 2^24 > a * min_distance
	assign lhs = RW'(t_s5) <<< MW;
	assign rhs = $signed((RW'(pp_hi_s5) << LOW) + RW'(pp_lo_s5));

	always_ff @(posedge clk) begin
		if (vld_s5 && rdy6) hit_s6 <= !fail_s5 && (rhs < lhs);
	end

	assign out_valid = vld_s6;
	assign hit       = hit_s6;

endmodule

// File: hdl/ray_triangle_intersect_unit.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect_unit: Moller-Trumbore ray/triangle hit test
// Exact fixed-point test, no division; one hit bit per word.
//
//  channel | signals                                | direction
//  --------+----------------------------------------+----------
//  in      | in_valid in_ready ray_* vertex_*       | sink
//  out     | out_valid out_ready hit                | source
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data | sink
//
// Six register stages; a word enters every cycle while out is not stalled.
// The two dot-product/cross-product stages set the stage depth.
// Reset clears all stage valids and loads the default registers.
// A stall on out holds only the stages that are full; bubbles collapse.
// cfg writes are always accepted and take effect in the next cycle.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_unit #(
	parameter int COORD_BITS = 20
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [rti_pkg::FIELD_W-1:0] ray_origin,
	input  logic [rti_pkg::FIELD_W-1:0] ray_direction,
	input  logic [rti_pkg::FIELD_W-1:0] vertex_a,
	input  logic [rti_pkg::FIELD_W-1:0] vertex_b,
	input  logic [rti_pkg::FIELD_W-1:0] vertex_c,
	output logic out_valid,
	input  logic out_ready,
	output logic hit,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [rti_pkg::EPS_W-1:0] cfg_data
);
	localparam int C  = COORD_BITS;
	localparam int DW = C + 1;
	localparam int XW = 2 * C + 3;
	localparam int AW = 3 * C + 6;

	logic [rti_pkg::EPS_W-1:0]  det_eps_q;
	logic [rti_pkg::MIND_W-1:0] min_dist_q;
	logic signed [DW-1:0] d_w [3], e1_w [3], e2_w [3], s_w [3];
	logic signed [XW-1:0] h_w [3], q_w [3];
	logic signed [AW-1:0] a_w, u_w, v_w, t_w;
	logic fr_valid, fr_ready, dt_valid, dt_ready;

	assign cfg_ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_eps_q  <= rti_pkg::EPS_RESET;
			min_dist_q <= rti_pkg::MIND_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rti_pkg::CFG_DET_EPSILON:  det_eps_q  <= cfg_data;
				rti_pkg::CFG_MIN_DISTANCE: min_dist_q <= cfg_data[rti_pkg::MIND_W-1:0];
				default: ;
			endcase
		end
	end

	rti_front #(.C(C)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.ray_origin(ray_origin), .ray_direction(ray_direction),
		.vertex_a(vertex_a), .vertex_b(vertex_b), .vertex_c(vertex_c),
		.out_valid(fr_valid), .out_ready(fr_ready),
		.d_o(d_w), .e1_o(e1_w), .e2_o(e2_w), .s_o(s_w), .h_o(h_w), .q_o(q_w)
	);

	rti_dot #(.C(C)) u_dot (
		.clk(clk), .arst_n(arst_n),
		.in_valid(fr_valid), .in_ready(fr_ready),
		.d_i(d_w), .e1_i(e1_w), .e2_i(e2_w), .s_i(s_w), .h_i(h_w), .q_i(q_w),
		.out_valid(dt_valid), .out_ready(dt_ready),
		.a_o(a_w), .u_o(u_w), .v_o(v_w), .t_o(t_w)
	);

	rti_test #(.C(C)) u_test (
		.clk(clk), .arst_n(arst_n),
		.in_valid(dt_valid), .in_ready(dt_ready),
		.a_i(a_w), .u_i(u_w), .v_i(v_w), .t_i(t_w),
		.det_epsilon(det_eps_q), .min_distance(min_dist_q),
		.out_valid(out_valid), .out_ready(out_ready), .hit(hit)
	);

	// An empty output stage never blocks the input
	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready) else $error("input blocked with empty output");

	// Back-pressure reaches the input only through a stalled result
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready)) else $error("spurious input stall");

	// Epsilon write lands
	a_eps_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_index == rti_pkg::CFG_DET_EPSILON) |=>
		det_eps_q == $past(cfg_data)) else $error("det_epsilon write lost");

	// Distance write lands
	a_mind_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_index == rti_pkg::CFG_MIN_DISTANCE) |=>
		min_dist_q == $past(cfg_data[rti_pkg::MIND_W-1:0]))
		else $error("min_distance write lost");

endmodule
